### rtl/kca_pkg.sv
// ----------------------------------------------------------------------------
// kca_pkg: shared types and constants of the keypad code alarm controller
// Op codes, event codes, mode encoding, reset values and the code compare.
// ----------------------------------------------------------------------------
package kca_pkg;

  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int SMOKE_W    = 12;
  localparam int MODE_W     = 2;
  localparam int EVENT_W    = 3;
  localparam int CODE_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int SLOT_W     = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_KEY        = 3'd0;
  localparam logic [OP_W-1:0] OP_SMOKE      = 3'd1;
  localparam logic [OP_W-1:0] OP_MOTION     = 3'd2;
  localparam logic [OP_W-1:0] OP_SERIAL     = 3'd3;
  localparam logic [OP_W-1:0] OP_LINE_ERR   = 3'd4;
  localparam logic [OP_W-1:0] OP_TIMEOUT    = 3'd5;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ARMED    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DISARMED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_PANIC    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_SMOKE    = 3'd5;
  localparam logic [EVENT_W-1:0] EV_MOTION   = 3'd6;
  localparam logic [EVENT_W-1:0] EV_LINE_ERR = 3'd7;

  // output mode codes
  localparam logic [MODE_W-1:0] MODE_CODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_ARMED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_RINGING = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCESS_CODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOKE_THRESHOLD = 1'd1;

  localparam logic [CODE_W-1:0]  ACCESS_CODE_RESET     = 32'h3132_3334; // "1234"
  localparam logic [SMOKE_W-1:0] SMOKE_THRESHOLD_RESET = 12'h744;
  localparam logic [CHAR_W-1:0]  PANIC_KEY             = 8'h2A;        // '*'
  localparam logic [CHAR_W-1:0]  NULL_KEY              = 8'h00;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'b001,
    MODE_ARMED   = 3'b010,
    MODE_RINGING = 3'b100
  } mode_t;

  typedef logic [3:0][CHAR_W-1:0] char_buf_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  char_in;
    logic [SMOKE_W-1:0] smoke_sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [CODE_W-1:0]  access_code;
    logic [SMOKE_W-1:0] smoke_threshold;
  } cfg_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_ARMED:   c = MODE_CODE_ARMED;
      MODE_RINGING: c = MODE_CODE_RINGING;
      default:      c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

  // entry 0 holds the first character, compared with code bits 31..24
  function automatic logic code_match(input char_buf_t buf_in,
                                      input logic [CODE_W-1:0] code);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (buf_in[i] != code[CODE_W-1-CHAR_W*i -: CHAR_W]) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### rtl/kca_item_if.sv
// ----------------------------------------------------------------------------
// kca_item_if: input event channel
// One transaction carries one event item.
// ----------------------------------------------------------------------------
interface kca_item_if;
  logic                       valid;
  logic                       ready;
  logic [kca_pkg::OP_W-1:0]    op;
  logic [kca_pkg::CHAR_W-1:0]  char_in;
  logic [kca_pkg::SMOKE_W-1:0] smoke_sample;

  modport source (output valid, output op, output char_in, output smoke_sample,
                  input ready);
  modport sink   (input valid, input op, input char_in, input smoke_sample,
                  output ready);
endinterface

### rtl/kca_result_if.sv
// ----------------------------------------------------------------------------
// kca_result_if: result channel
// One transaction carries the alarm status after one event.
// ----------------------------------------------------------------------------
interface kca_result_if;
  logic                       valid;
  logic                       ready;
  logic [kca_pkg::MODE_W-1:0]  alarm_mode;
  logic [kca_pkg::EVENT_W-1:0] event_code;
  logic                       siren_on;
  logic                       armed_lamp;

  modport source (output valid, output alarm_mode, output event_code,
                  output siren_on, output armed_lamp, input ready);
  modport sink   (input valid, input alarm_mode, input event_code,
                  input siren_on, input armed_lamp, output ready);
endinterface

### rtl/kca_cfg_if.sv
// ----------------------------------------------------------------------------
// kca_cfg_if: configuration write channel
// One transaction writes one register by index.
// ----------------------------------------------------------------------------
interface kca_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kca_pkg::CFG_IDX_W-1:0] index;
  logic [kca_pkg::CODE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/kca_cfg_regs.sv
// ----------------------------------------------------------------------------
// kca_cfg_regs: configuration registers
// Access code and smoke threshold, written through the config channel.
// ----------------------------------------------------------------------------
module kca_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  kca_cfg_if.sink         cfg,
  output kca_pkg::cfg_t   regs
);
  import kca_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.access_code     <= ACCESS_CODE_RESET;
      regs.smoke_threshold <= SMOKE_THRESHOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ACCESS_CODE:     regs.access_code     <= cfg.data;
        REG_SMOKE_THRESHOLD: regs.smoke_threshold <= cfg.data[SMOKE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/kca_input_stage.sv
// ----------------------------------------------------------------------------
// kca_input_stage: input register
// Captures one event per cycle; holds it while the result side stalls.
// ----------------------------------------------------------------------------
module kca_input_stage (
  input  logic            clk,
  input  logic            rst,
  kca_item_if.sink        item,
  input  logic            advance,
  output kca_pkg::stage_t stage
);
  import kca_pkg::*;

  // free when empty or when the held item moves on this cycle
  assign item.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (item.ready) begin
      stage.valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      stage.item.op           <= item.op;
      stage.item.char_in      <= item.char_in;
      stage.item.smoke_sample <= item.smoke_sample;
    end
  end

endmodule

### rtl/kca_event_core.sv
// ----------------------------------------------------------------------------
// kca_event_core: alarm state and result register
// Applies one event to mode, siren and code buffers; registers the result.
// ----------------------------------------------------------------------------
module kca_event_core (
  input  logic            clk,
  input  logic            rst,
  input  kca_pkg::stage_t stage,
  input  kca_pkg::cfg_t   regs,
  output logic            advance,
  kca_result_if.source    result
);
  import kca_pkg::*;

  mode_t                mode;
  logic                 siren;
  char_buf_t            key_store;
  logic [SLOT_W-1:0]    key_slot;
  char_buf_t            serial_store;
  logic [SLOT_W-1:0]    serial_slot;

  mode_t                mode_next;
  logic                 siren_next;
  char_buf_t            key_store_next;
  logic [SLOT_W-1:0]    key_slot_next;
  char_buf_t            serial_store_next;
  logic [SLOT_W-1:0]    serial_slot_next;
  logic [EVENT_W-1:0]   event_next;
  logic                 load;
  logic                 panic;

  assign advance = !result.valid || result.ready;
  assign load    = stage.valid && advance;

  always_comb begin
    mode_next         = mode;
    siren_next        = siren;
    key_store_next    = key_store;
    key_slot_next     = key_slot;
    serial_store_next = serial_store;
    serial_slot_next  = serial_slot;
    event_next        = EV_NONE;
    panic             = 1'b0;

    case (stage.item.op)
      OP_KEY: begin
        if (stage.item.char_in != NULL_KEY) begin
          key_store_next[key_slot] = stage.item.char_in;
          // two '*' in a row; never checked at the first slot
          panic = (key_slot != '0) && (stage.item.char_in == PANIC_KEY) &&
                  (key_store[key_slot - SLOT_W'(1)] == PANIC_KEY);
          if (panic) begin
            mode_next     = MODE_RINGING;
            event_next    = EV_PANIC;
            key_slot_next = '0;
          end else begin
            if (key_slot == '1) begin
              if (code_match(key_store_next, regs.access_code)) begin
                if (mode == MODE_OFF) begin
                  mode_next  = MODE_ARMED;
                  event_next = EV_ARMED;
                end else begin
                  mode_next  = MODE_OFF;
                  siren_next = 1'b0;
                  event_next = EV_DISARMED;
                end
              end else begin
                event_next = EV_WRONG;
              end
            end
            key_slot_next = key_slot + SLOT_W'(1);
          end
        end
      end
      OP_SMOKE, OP_MOTION: begin
        if ((stage.item.op == OP_MOTION ||
             stage.item.smoke_sample > regs.smoke_threshold) &&
            mode == MODE_ARMED) begin
          mode_next  = MODE_RINGING;
          siren_next = 1'b1;
          event_next = (stage.item.op == OP_SMOKE) ? EV_SMOKE : EV_MOTION;
        end
      end
      OP_SERIAL: begin
        serial_store_next[serial_slot] = stage.item.char_in;
        serial_slot_next               = serial_slot + SLOT_W'(1);
        // wrong serial code stays silent
        if (serial_slot == '1 &&
            code_match(serial_store_next, regs.access_code)) begin
          if (mode == MODE_OFF) begin
            mode_next  = MODE_ARMED;
            event_next = EV_ARMED;
          end else begin
            mode_next  = MODE_OFF;
            siren_next = 1'b0;
            event_next = EV_DISARMED;
          end
        end
      end
      OP_LINE_ERR: event_next = EV_LINE_ERR;
      OP_TIMEOUT:  key_slot_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_OFF;
      siren        <= 1'b0;
      key_store    <= '0;
      key_slot     <= '0;
      serial_store <= '0;
      serial_slot  <= '0;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        mode         <= mode_next;
        siren        <= siren_next;
        key_store    <= key_store_next;
        key_slot     <= key_slot_next;
        serial_store <= serial_store_next;
        serial_slot  <= serial_slot_next;
      end
      if (advance) result.valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.alarm_mode <= mode_code(mode_next);
      result.event_code <= event_next;
      result.siren_on   <= siren_next;
      result.armed_lamp <= (mode_next != MODE_OFF);
    end
  end

  // siren only ever sounds while ringing
  a_siren_ringing: assert property (@(posedge clk) disable iff (rst)
    siren |-> mode == MODE_RINGING)
    else $error("siren on outside ringing mode");

  // a panic clears the key slot
  a_panic_slot: assert property (@(posedge clk) disable iff (rst)
    (load && panic) |=> key_slot == '0)
    else $error("key slot not cleared after panic");

  // an arm event reports armed mode with the lamp lit
  a_arm_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.event_code == EV_ARMED) |->
      (result.alarm_mode == MODE_CODE_ARMED && result.armed_lamp))
    else $error("arm event with wrong mode");

  // a disarm event reports off with siren stopped
  a_disarm_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.event_code == EV_DISARMED) |->
      (result.alarm_mode == MODE_CODE_OFF && !result.siren_on &&
       !result.armed_lamp))
    else $error("disarm event with siren or mode left on");

  // state moves only together with a result
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(mode) && $stable(key_slot) && $stable(serial_slot))
    else $error("state changed without an item");

endmodule

### rtl/keypad_code_alarm_controller.sv
// ----------------------------------------------------------------------------
// keypad_code_alarm_controller: security alarm mode controller
// Keypad and serial code entry, panic, smoke and motion triggering.
// ----------------------------------------------------------------------------
// Each item is registered in the input stage, then its result in the result register.
// Throughput: one item per cycle while results are read, set by the single event stage.
// The input register takes a new item while a finished result waits unread, if it is empty.
// Reset (rst, synchronous): alarm off, siren off, code buffers and slots zero,
// access code "1234", smoke threshold 0x744, both channels empty.
module keypad_code_alarm_controller (
  input  logic        clk,
  input  logic        rst,
  kca_item_if.sink     item,
  kca_result_if.source result,
  kca_cfg_if.sink      cfg
);
  import kca_pkg::*;

  cfg_t   regs;
  stage_t stage;
  logic   advance;

  // register file; writes must arrive only while the block is idle (not enforced here)
  kca_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register, stalls together with the result register
  kca_input_stage u_input_stage (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .advance (advance),
    .stage   (stage)
  );

  // mode, siren and code buffers; one transaction updates them and loads
  // the result register in the same cycle
  kca_event_core u_event_core (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .regs    (regs),
    .advance (advance),
    .result  (result)
  );

endmodule
